### design/ncs_pkg.sv
// shared types and constants for the nearest palette color search block
package ncs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CHAN_W          = 8;
  localparam int COLOR_W         = 3 * CHAN_W;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = SQ_W + 2;
  localparam int OUT_IDX_W       = 8;

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // marks one palette entry as it moves down the scan pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

### design/ncs_palette_ram.sv
// palette storage: one write port, one registered read port
module ncs_palette_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ncs_pkg::IDX_W-1:0]   waddr,
  input  logic [ncs_pkg::COLOR_W-1:0] wdata,
  input  logic [ncs_pkg::IDX_W-1:0]   raddr,
  output logic [ncs_pkg::COLOR_W-1:0] rdata
);
  import ncs_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/ncs_dist_unit.sv
// shared distance unit: squares per channel, then sum and running minimum
module ncs_dist_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  ncs_pkg::scan_tag_t            tag,
  input  logic [ncs_pkg::COLOR_W-1:0]   entry,
  input  logic [ncs_pkg::CHAN_W-1:0]    qr,
  input  logic [ncs_pkg::CHAN_W-1:0]    qg,
  input  logic [ncs_pkg::CHAN_W-1:0]    qb,
  output logic                          done,
  output logic [ncs_pkg::OUT_IDX_W-1:0] best_index
);
  import ncs_pkg::*;

  logic [CHAN_W-1:0] er, eg, eb;
  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  scan_tag_t         tag2;
  logic [DIST_W-1:0] cur_dist;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best;
  logic              take;
  logic [IDX_W-1:0]  best_next;

  assign er = entry[COLOR_W-1 -: CHAN_W];
  assign eg = entry[SQ_W-1 -: CHAN_W];
  assign eb = entry[CHAN_W-1:0];

  // absolute channel differences
  assign dr = (er > qr) ? (er - qr) : (qr - er);
  assign dg = (eg > qg) ? (eg - qg) : (qg - eg);
  assign db = (eb > qb) ? (eb - qb) : (qb - eb);

  always_ff @(posedge clk) begin
    sq_r <= SQ_W'(dr) * SQ_W'(dr);
    sq_g <= SQ_W'(dg) * SQ_W'(dg);
    sq_b <= SQ_W'(db) * SQ_W'(db);
    if (rst) begin
      tag2.valid <= 1'b0;
    end else begin
      tag2 <= tag;
    end
  end

  assign cur_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // strictly smaller wins, so ties keep the lower slot
  assign take      = tag2.valid && (tag2.first || (cur_dist < best_dist));
  assign best_next = take ? tag2.idx : best;

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist <= cur_dist;
      best      <= tag2.idx;
    end
    if (tag2.valid && tag2.last) begin
      best_index <= OUT_IDX_W'(best_next);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag2.valid && tag2.last;
    end
  end

endmodule

### design/nearest_palette_color_search_top.sv
// top level of the nearest palette color search block
//
// command channel: a beat is taken at a rising edge with start high and busy
// low. action selects a palette write or a nearest-color query.
// a write stores {red, green, blue} into slot entry_index and
// gives no result; busy stays low, so writes may come every cycle. slots at
// or beyond the palette size are ignored.
// a query latches its color and scans every slot once, one slot per cycle,
// through the palette memory's single read port and a shared distance unit
// (memory read, square per channel, sum and compare).
// the result beat (best_index) shows on the done strobe for one cycle and is
// taken once the last slot has passed the read, square and compare stages;
// busy rises as the query beat is taken and stays high through the done
// cycle, so the next command beat can follow a query only once done has
// shown, a wait set by the one-slot-per-cycle memory port and those stages.
// the receiver cannot stall: the result is there for exactly one cycle.
// reset clears the sequencer and the strobe; the palette keeps no reset
// value, and every slot must be written before the first query.
module nearest_palette_color_search_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [7:0]                    entry_index,
  input  logic [ncs_pkg::CHAN_W-1:0]    red,
  input  logic [ncs_pkg::CHAN_W-1:0]    green,
  input  logic [ncs_pkg::CHAN_W-1:0]    blue,
  output logic                          done,
  output logic [ncs_pkg::OUT_IDX_W-1:0] best_index
);
  import ncs_pkg::*;

  state_t             state, state_next;
  logic               accept;
  logic               issue;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   addr;
  logic [CHAN_W-1:0]  qr, qg, qb;
  logic [COLOR_W-1:0] rdata;
  scan_tag_t          tag1;

  assign accept = start && !busy;

  // palette write, dropped when the slot lies outside the palette
  assign waddr = IDX_W'(entry_index);
  assign we    = accept && (action == ACT_WRITE) &&
                 (32'(entry_index) < 32'(PALETTE_ENTRIES));

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_QUERY)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (addr == LAST_ADDR) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state)
      ST_IDLE:  busy  = 1'b0;
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: issue = 1'b0;
      default:  busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    // query color held for the whole scan
    if (accept && (action == ACT_QUERY)) begin
      qr   <= red;
      qg   <= green;
      qb   <= blue;
      addr <= '0;
    end else if (issue) begin
      addr <= addr + IDX_W'(1);
    end
    // tag lines up with the registered memory read
    tag1.first <= (addr == '0);
    tag1.last  <= (addr == LAST_ADDR);
    tag1.idx   <= addr;
    if (rst) begin
      state      <= ST_IDLE;
      tag1.valid <= 1'b0;
    end else begin
      state      <= state_next;
      tag1.valid <= issue;
    end
  end

  ncs_palette_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({red, green, blue}),
    .raddr (addr),
    .rdata (rdata)
  );

  ncs_dist_unit u_dist (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag1),
    .entry      (rdata),
    .qr         (qr),
    .qg         (qg),
    .qb         (qb),
    .done       (done),
    .best_index (best_index)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the nearest palette color search block
module tb_top;
  import ncs_pkg::*;

  localparam int CHAN_MAX     = (1 << CHAN_W) - 1;
  // a query runs one full palette scan plus its drain; give the tail some margin
  localparam int DRAIN_CYCLES = PALETTE_ENTRIES + 16;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 action;
  logic [7:0]           entry_index;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 done;
  logic [OUT_IDX_W-1:0] best_index;

  // shadow copy of the palette, kept in step with every accepted write beat
  logic [COLOR_W-1:0]   palette_shadow [PALETTE_ENTRIES];
  // winning slots of accepted queries, oldest first
  logic [OUT_IDX_W-1:0] pending_slots [$];
  int                   error_count;
  // idle gaps on the command side are switched off for the burst test
  bit                   sender_idles;

  nearest_palette_color_search_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .done        (done),
    .best_index  (best_index)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scan every slot from zero up; only a strictly smaller distance takes over,
  // so the lowest slot wins a tie
  function automatic logic [OUT_IDX_W-1:0] nearest_slot(input logic [CHAN_W-1:0] r,
                                                        input logic [CHAN_W-1:0] g,
                                                        input logic [CHAN_W-1:0] b);
    int          dr;
    int          dg;
    int          db;
    int unsigned cur_dist;
    int unsigned best_dist;
    int          best;
    best      = 0;
    best_dist = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr       = int'(palette_shadow[i][2*CHAN_W +: CHAN_W]) - int'(r);
      dg       = int'(palette_shadow[i][CHAN_W +: CHAN_W]) - int'(g);
      db       = int'(palette_shadow[i][0 +: CHAN_W]) - int'(b);
      cur_dist = dr * dr + dg * dg + db * db;
      if (i == 0 || cur_dist < best_dist) begin
        best_dist = cur_dist;
        best      = i;
      end
    end
    return OUT_IDX_W'(best);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    return CHAN_W'($urandom_range(CHAN_MAX));
  endfunction

  // one of four levels per channel, so the palette fills with duplicates
  function automatic logic [CHAN_W-1:0] level_chan();
    return CHAN_W'($urandom_range(3) * 85);
  endfunction

  // small step around a channel value, clamped to the channel range
  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(8)) - 4;
    if (v < 0) begin
      v = 0;
    end else if (v > CHAN_MAX) begin
      v = CHAN_MAX;
    end
    return CHAN_W'(v);
  endfunction

  // drive one beat and hold it until the block takes it, then update the
  // shadow palette or queue the expected winner
  task automatic send_beat(input logic act, input logic [7:0] idx,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b);
    int gap;
    if (sender_idles && $urandom_range(99) < 30) begin
      // mostly short gaps, now and then one long enough to land mid-scan
      gap = ($urandom_range(99) < 5) ? $urandom_range(PALETTE_ENTRIES + 40, 1)
                                     : $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (busy);
    if (act == ACT_WRITE) begin
      if (int'(idx) < PALETTE_ENTRIES) begin
        palette_shadow[idx] = {r, g, b};
      end
    end else begin
      pending_slots.push_back(nearest_slot(r, g, b));
    end
  endtask

  task automatic query_near_entry();
    logic [COLOR_W-1:0] c;
    c = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
    send_beat(ACT_QUERY, 8'($urandom), nudge(c[2*CHAN_W +: CHAN_W]),
              nudge(c[CHAN_W +: CHAN_W]), nudge(c[0 +: CHAN_W]));
  endtask

  // every slot gets mid gray, so all slots tie until overwritten
  task automatic test_fill_gray();
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      send_beat(ACT_WRITE, 8'(i), 8'h80, 8'h80, 8'h80);
    end
  endtask

  task automatic test_directed();
    // full tie across the palette: slot zero wins
    send_beat(ACT_QUERY, 8'hff, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    // winner in the last slot
    send_beat(ACT_WRITE, 8'hff, 8'hff, 8'hff, 8'hff);
    send_beat(ACT_QUERY, 8'h5a, 8'hff, 8'hff, 8'hff);
    send_beat(ACT_QUERY, 8'ha5, 8'hc8, 8'hc8, 8'hc8);
    // same color twice: the lower slot takes it
    send_beat(ACT_WRITE, 8'd100, 8'hff, 8'hff, 8'hff);
    send_beat(ACT_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    // black in slot zero
    send_beat(ACT_WRITE, 8'h00, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_QUERY, 8'h00, 8'd1, 8'd2, 8'd3);
    // two different colors at equal distance from the query
    send_beat(ACT_WRITE, 8'd10, 8'd60, 8'd50, 8'd50);
    send_beat(ACT_WRITE, 8'd20, 8'd50, 8'd60, 8'd50);
    send_beat(ACT_QUERY, 8'h00, 8'd55, 8'd55, 8'd50);
    // pure primaries, one channel at full scale each
    send_beat(ACT_WRITE, 8'd128, 8'hff, 8'h00, 8'h00);
    send_beat(ACT_WRITE, 8'd129, 8'h00, 8'hff, 8'h00);
    send_beat(ACT_WRITE, 8'd130, 8'h00, 8'h00, 8'hff);
    send_beat(ACT_QUERY, 8'h00, 8'hff, 8'h00, 8'h00);
    send_beat(ACT_QUERY, 8'h00, 8'h00, 8'hff, 8'h00);
    send_beat(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'hff);
  endtask

  // full-range random palette, then a mix of rewrites and queries
  task automatic test_random_palette(input int beats);
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      send_beat(ACT_WRITE, 8'(i), rand_chan(), rand_chan(), rand_chan());
    end
    for (int n = 0; n < beats; n++) begin
      if ($urandom_range(99) < 50) begin
        send_beat(ACT_WRITE, 8'($urandom), rand_chan(), rand_chan(), rand_chan());
      end else if ($urandom_range(1) == 0) begin
        send_beat(ACT_QUERY, 8'($urandom), rand_chan(), rand_chan(), rand_chan());
      end else begin
        query_near_entry();
      end
    end
  endtask

  // palette of a few repeated colors; queries on midpoints give many ties
  task automatic test_repeated_colors(input int beats);
    int pick;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      send_beat(ACT_WRITE, 8'(i), level_chan(), level_chan(), level_chan());
    end
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_beat(ACT_WRITE, 8'($urandom), level_chan(), level_chan(), level_chan());
      end else if (pick < 70) begin
        send_beat(ACT_QUERY, 8'($urandom), CHAN_W'($urandom_range(6) * 42),
                  CHAN_W'($urandom_range(6) * 42), CHAN_W'($urandom_range(6) * 42));
      end else if (pick < 85) begin
        send_beat(ACT_QUERY, 8'($urandom), level_chan(), level_chan(), level_chan());
      end else begin
        query_near_entry();
      end
    end
  endtask

  // no idle cycles: runs of back-to-back writes with queries in between
  task automatic test_back_to_back(input int beats);
    int sent;
    int run;
    sent         = 0;
    sender_idles = 1'b0;
    while (sent < beats) begin
      run = $urandom_range(12, 1);
      for (int k = 0; k < run; k++) begin
        send_beat(ACT_WRITE, 8'($urandom), rand_chan(), rand_chan(), rand_chan());
      end
      sent += run;
      run = $urandom_range(3, 1);
      for (int k = 0; k < run; k++) begin
        if ($urandom_range(1) == 0) begin
          query_near_entry();
        end else begin
          send_beat(ACT_QUERY, 8'($urandom), rand_chan(), rand_chan(), rand_chan());
        end
      end
      sent += run;
    end
    sender_idles = 1'b1;
  endtask

  // every done strobe is checked against the oldest queued query
  always @(posedge clk) begin : check_results
    logic [OUT_IDX_W-1:0] want;
    if (!rst && done) begin
      if (pending_slots.size() == 0) begin
        $error("best_index: expected none, actual %0d", best_index);
        error_count++;
      end else begin
        want = pending_slots.pop_front();
        if (best_index !== want) begin
          $error("best_index: expected %0d, actual %0d", want, best_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    sender_idles = 1'b1;
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_WRITE;
    entry_index <= '0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot is written before the first query
    test_fill_gray();
    test_directed();
    test_random_palette(450);
    test_repeated_colors(400);
    test_back_to_back(200);

    start <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
